### design/lcd_rect_fill_command_stream_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle-fill command stream
// Shared concurrent assertion forms, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef LCD_RECT_FILL_COMMAND_STREAM_MACROS_SVH
`define LCD_RECT_FILL_COMMAND_STREAM_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define LCDRF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included
`define LCDRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/lcdrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdrf_pkg
// Types and constants shared by the rectangle-fill command stream modules.
// ----------------------------------------------------------------------------
package lcdrf_pkg;

   // Input item kinds
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Configuration register indexes
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   // Display controller opcodes
   localparam logic [7:0] OP_COLUMN_WINDOW = 8'h2A;
   localparam logic [7:0] OP_ROW_WINDOW    = 8'h2B;
   localparam logic [7:0] OP_MEMORY_WRITE  = 8'h2C;

   localparam int unsigned COORD_W = 10;
   localparam int unsigned LEFT_W  = 21;

   typedef enum logic {
      JOB_PIXEL,
      JOB_HEADER
   } job_kind_type;

   // One queued unit of output work
   typedef struct packed {
      job_kind_type       kind;
      logic [7:0]         pix_byte;
      logic               done;
      logic [COORD_W-1:0] x_first;
      logic [COORD_W-1:0] x_last;
      logic [COORD_W-1:0] y_first;
      logic [COORD_W-1:0] y_last;
   } job_type;

   // Header burst sequence
   typedef enum logic [3:0] {
      HDR_COL_CMD,
      HDR_COL_FIRST_HI,
      HDR_COL_FIRST_LO,
      HDR_COL_LAST_HI,
      HDR_COL_LAST_LO,
      HDR_ROW_CMD,
      HDR_ROW_FIRST_HI,
      HDR_ROW_FIRST_LO,
      HDR_ROW_LAST_HI,
      HDR_ROW_LAST_LO,
      HDR_MEM_CMD
   } hdr_step_type;

endpackage

### design/lcdrf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdrf_front
// Accepts items, clips start rectangles, tracks the pixel byte count and
// queues header or pixel jobs for the output side.
// ----------------------------------------------------------------------------
module lcdrf_front
   import lcdrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                cmd,
   input  logic [10:0]         rect_x,
   input  logic [10:0]         rect_y,
   input  logic [10:0]         rect_w,
   input  logic [10:0]         rect_h,
   input  logic [15:0]         fill_colour,
   input  logic [COORD_W-1:0]  screen_width,
   input  logic [COORD_W-1:0]  screen_height,
   input  logic                queue_full,
   output logic                push,
   output job_type             push_job
);

   logic [LEFT_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [15:0]        colour_ff, colour_in;
   logic               pend_ff, pend_in;
   logic [COORD_W-1:0] w_ff, w_in;
   logic [COORD_W-1:0] h_ff, h_in;
   logic [2*COORD_W-1:0] area;

   logic signed [12:0] x_s, y_s, w_s, h_s;
   logic signed [12:0] xa, ya, wa, ha, wc, hc;
   logic signed [12:0] sw_s, sh_s, x_end, y_end;
   logic               accept, busy, fits;

   assign req_ready = !pend_ff && !queue_full;
   assign accept    = req_valid && req_ready;
   assign busy      = (bytes_left_ff != '0);
   assign area      = w_ff * h_ff;

   // Clip the requested rectangle to the screen
   always_comb begin
      x_s  = {{2{rect_x[10]}}, rect_x};
      y_s  = {{2{rect_y[10]}}, rect_y};
      w_s  = {{2{rect_w[10]}}, rect_w};
      h_s  = {{2{rect_h[10]}}, rect_h};
      sw_s = {3'b000, screen_width};
      sh_s = {3'b000, screen_height};
      xa   = x_s[12] ? 13'sd0 : x_s;
      ya   = y_s[12] ? 13'sd0 : y_s;
      wa   = x_s[12] ? (w_s + x_s) : w_s;
      ha   = y_s[12] ? (h_s + y_s) : h_s;
      wc   = ((xa + wa) > sw_s) ? (sw_s - xa) : wa;
      hc   = ((ya + ha) > sh_s) ? (sh_s - ya) : ha;
      x_end = xa + wc - 13'sd1;
      y_end = ya + hc - 13'sd1;
      fits = (wc > 13'sd0) && (hc > 13'sd0);
   end

   // Classify the item and update the fill state
   always_comb begin
      bytes_left_in = bytes_left_ff;
      colour_in     = colour_ff;
      pend_in       = 1'b0;
      w_in          = w_ff;
      h_in          = h_ff;
      push          = 1'b0;
      push_job      = '0;
      if (pend_ff) begin
         bytes_left_in = {area, 1'b0};
      end else if (accept) begin
         if (cmd == CMD_TICK) begin
            if (busy) begin
               push              = 1'b1;
               push_job.kind     = JOB_PIXEL;
               push_job.pix_byte = bytes_left_ff[0] ? colour_ff[7:0] : colour_ff[15:8];
               push_job.done     = (bytes_left_ff == LEFT_W'(1));
               bytes_left_in     = bytes_left_ff - LEFT_W'(1);
            end
         end else if (!busy && fits) begin
            push             = 1'b1;
            push_job.kind    = JOB_HEADER;
            push_job.x_first = xa[COORD_W-1:0];
            push_job.x_last  = x_end[COORD_W-1:0];
            push_job.y_first = ya[COORD_W-1:0];
            push_job.y_last  = y_end[COORD_W-1:0];
            colour_in        = fill_colour;
            w_in             = wc[COORD_W-1:0];
            h_in             = hc[COORD_W-1:0];
            pend_in          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         colour_ff     <= '0;
         pend_ff       <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         colour_ff     <= colour_in;
         pend_ff       <= pend_in;
      end
      w_ff <= w_in;
      h_ff <= h_in;
   end

endmodule

### design/lcdrf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdrf_queue
// Short first-word-fall-through job queue between the front and back ends.
// ----------------------------------------------------------------------------
module lcdrf_queue
   import lcdrf_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = store_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/lcdrf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdrf_back
// Expands queued jobs into bytes: an eleven-byte window header or a single
// pixel byte, through a registered output stage.
// ----------------------------------------------------------------------------
module lcdrf_back
   import lcdrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser
);

   hdr_step_type step_ff, step_in;
   hdr_step_type step_next;
   logic         valid_ff, valid_in;
   logic [7:0]   byte_ff, byte_in;
   logic         data_ff, data_in;
   logic         last_ff, last_in;
   logic         done_ff, done_in;
   logic [7:0]   hdr_byte;
   logic         hdr_data;
   logic         load;

   assign load       = head_valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {done_ff, data_ff};

   // Select the header byte for the current step
   always_comb begin
      hdr_data  = 1'b1;
      hdr_byte  = '0;
      step_next = HDR_COL_CMD;
      unique case (step_ff)
         HDR_COL_CMD: begin
            hdr_data  = 1'b0;
            hdr_byte  = OP_COLUMN_WINDOW;
            step_next = HDR_COL_FIRST_HI;
         end
         HDR_COL_FIRST_HI: begin
            hdr_byte  = {6'b0, head_job.x_first[9:8]};
            step_next = HDR_COL_FIRST_LO;
         end
         HDR_COL_FIRST_LO: begin
            hdr_byte  = head_job.x_first[7:0];
            step_next = HDR_COL_LAST_HI;
         end
         HDR_COL_LAST_HI: begin
            hdr_byte  = {6'b0, head_job.x_last[9:8]};
            step_next = HDR_COL_LAST_LO;
         end
         HDR_COL_LAST_LO: begin
            hdr_byte  = head_job.x_last[7:0];
            step_next = HDR_ROW_CMD;
         end
         HDR_ROW_CMD: begin
            hdr_data  = 1'b0;
            hdr_byte  = OP_ROW_WINDOW;
            step_next = HDR_ROW_FIRST_HI;
         end
         HDR_ROW_FIRST_HI: begin
            hdr_byte  = {6'b0, head_job.y_first[9:8]};
            step_next = HDR_ROW_FIRST_LO;
         end
         HDR_ROW_FIRST_LO: begin
            hdr_byte  = head_job.y_first[7:0];
            step_next = HDR_ROW_LAST_HI;
         end
         HDR_ROW_LAST_HI: begin
            hdr_byte  = {6'b0, head_job.y_last[9:8]};
            step_next = HDR_ROW_LAST_LO;
         end
         HDR_ROW_LAST_LO: begin
            hdr_byte  = head_job.y_last[7:0];
            step_next = HDR_MEM_CMD;
         end
         HDR_MEM_CMD: begin
            hdr_data  = 1'b0;
            hdr_byte  = OP_MEMORY_WRITE;
            step_next = HDR_COL_CMD;
         end
         default: begin
            hdr_byte  = '0;
            step_next = HDR_COL_CMD;
         end
      endcase
   end

   // Load the output stage and step through the job
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      step_in  = step_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head_job.kind == JOB_PIXEL) begin
            byte_in = head_job.pix_byte;
            data_in = 1'b1;
            last_in = 1'b1;
            done_in = head_job.done;
            pop     = 1'b1;
         end else begin
            byte_in = hdr_byte;
            data_in = hdr_data;
            last_in = (step_ff == HDR_MEM_CMD);
            done_in = 1'b0;
            step_in = step_next;
            pop     = (step_ff == HDR_MEM_CMD);
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= HDR_COL_CMD;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
      byte_ff <= byte_in;
      data_ff <= data_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

endmodule

### design/lcd_rect_fill_command_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_rect_fill_command_stream
// Turns rectangle-fill starts and pixel ticks into the byte stream of a
// column/row address-window display controller.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  req_*   | in        | start (clip, header) or tick (one pixel byte)
//  rsp_*   | out       | command, address and pixel bytes, one per item
//  csr_*   | in/out    | screen_width at 0x0, screen_height at 0x4
//
// One item is accepted per cycle; after a start that survives clipping,
// req_tready drops for one cycle while the pixel count multiply settles.
// The output side sends one byte per cycle while rsp_tready is high: a header
// is eleven bytes and a pixel job one, so QUEUE_DEPTH jobs may wait between
// the two sides. req_tready also drops while the job queue is full.
// Reset is synchronous; it clears the fill and sets the screen to 320x240.
// ----------------------------------------------------------------------------
module lcd_rect_fill_command_stream
   import lcdrf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // rect_x, rect_y, rect_w, rect_h, fill_colour, zero pad
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // bus_byte
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // is_data, fill_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [COORD_W-1:0] width_ff, width_in;
   logic [COORD_W-1:0] height_ff, height_in;
   logic               csr_write;
   logic               push, pop, queue_full, head_valid;
   job_type            push_job, head_job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write and read-back
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_SCREEN_WIDTH) begin
            width_in = csr_pwdata[COORD_W-1:0];
         end else begin
            height_in = csr_pwdata[COORD_W-1:0];
         end
      end
      if (csr_paddr[2] == REG_SCREEN_WIDTH) begin
         csr_prdata = {22'b0, width_ff};
      end else begin
         csr_prdata = {22'b0, height_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= COORD_W'(320);
         height_ff <= COORD_W'(240);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   lcdrf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .cmd           (req_tuser),
      .rect_x        (req_tdata[10:0]),
      .rect_y        (req_tdata[21:11]),
      .rect_w        (req_tdata[32:22]),
      .rect_h        (req_tdata[43:33]),
      .fill_colour   (req_tdata[59:44]),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_job      (push_job)
   );

   lcdrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   lcdrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### design/lcdrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdrf_checker
// Port-level checks on the result stream of the rectangle-fill block.
// ----------------------------------------------------------------------------
`include "lcd_rect_fill_command_stream_macros.svh"

module lcdrf_checker
   import lcdrf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);

   // Hold a stalled item
   `LCDRF_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp item dropped while stalled")

   // Final pixel byte is data and closes its run
   `LCDRF_ASSERT(a_done_shape, clock, reset, rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && rsp_tlast, "fill_done on a non-final byte")

   // Command bytes are only the three display controller opcodes
   `LCDRF_ASSERT(a_cmd_code, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == OP_COLUMN_WINDOW) || (rsp_tdata == OP_ROW_WINDOW) || (rsp_tdata == OP_MEMORY_WRITE), "unknown command byte")

   // A run that ends on a command ends on memory write
   `LCDRF_ASSERT(a_cmd_last, clock, reset, rsp_tvalid && rsp_tlast && !rsp_tuser[0] |-> rsp_tdata == OP_MEMORY_WRITE, "header ends on wrong command")

   // Drop output after reset
   `LCDRF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind lcd_rect_fill_command_stream lcdrf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

### verif/lcd_fill_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_fill_stream_checker
// Watches the request, response and register channels of the rectangle-fill
// command stream. Every accepted item is run through a cycle-free model of
// the clipping, header and pixel logic, and every accepted response byte is
// compared field by field with the oldest byte still due.
// ----------------------------------------------------------------------------
module lcd_fill_stream_checker
   import lcdrf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // rect_x, rect_y, rect_w, rect_h, fill_colour, zero pad
   input  logic        req_tuser,   // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // bus_byte
   input  logic        rsp_tlast,
   input  logic [1:0]  rsp_tuser,   // is_data, fill_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          bytes_pending
);

   localparam logic [2:0] ADDR_SCREEN_WIDTH  = {REG_SCREEN_WIDTH, 2'b00};
   localparam logic [2:0] ADDR_SCREEN_HEIGHT = {REG_SCREEN_HEIGHT, 2'b00};
   localparam logic [9:0] RESET_WIDTH  = 10'd320;
   localparam logic [9:0] RESET_HEIGHT = 10'd240;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       is_data;
      logic       last_of_run;
      logic       fill_done;
   } link_byte_type;

   // Model state
   logic [9:0]        screen_w;
   logic [9:0]        screen_h;
   logic [LEFT_W-1:0] pixel_bytes_left;
   logic [15:0]       fill_rgb;

   link_byte_type bytes_due[$];
   int            errors;

   task automatic queue_byte(input logic [7:0] b, input logic data, input logic last,
                             input logic done);
      link_byte_type e;
      e.bus_byte    = b;
      e.is_data     = data;
      e.last_of_run = last;
      e.fill_done   = done;
      bytes_due.push_back(e);
   endtask

   // Opcode followed by first and last address, big-endian
   task automatic queue_window(input logic [7:0] op, input int first, input int last);
      logic [15:0] f;
      logic [15:0] l;
      f = 16'(first);
      l = 16'(last);
      queue_byte(op, 1'b0, 1'b0, 1'b0);
      queue_byte(f[15:8], 1'b1, 1'b0, 1'b0);
      queue_byte(f[7:0], 1'b1, 1'b0, 1'b0);
      queue_byte(l[15:8], 1'b1, 1'b0, 1'b0);
      queue_byte(l[7:0], 1'b1, 1'b0, 1'b0);
   endtask

   // Clip the rectangle and queue the header of a new fill
   task automatic predict_start(input logic [63:0] d);
      int x;
      int y;
      int w;
      int h;
      x = $signed(d[10:0]);
      y = $signed(d[21:11]);
      w = $signed(d[32:22]);
      h = $signed(d[43:33]);
      if (pixel_bytes_left != '0) return;
      if (x < 0) begin
         w = w + x;
         x = 0;
      end
      if (y < 0) begin
         h = h + y;
         y = 0;
      end
      if (x + w > int'(screen_w)) w = int'(screen_w) - x;
      if (y + h > int'(screen_h)) h = int'(screen_h) - y;
      if (w <= 0 || h <= 0) return;
      queue_window(OP_COLUMN_WINDOW, x, x + w - 1);
      queue_window(OP_ROW_WINDOW, y, y + h - 1);
      queue_byte(OP_MEMORY_WRITE, 1'b0, 1'b1, 1'b0);
      fill_rgb         = d[59:44];
      pixel_bytes_left = LEFT_W'(w * h * 2);
   endtask

   // Release one pixel byte, high byte of the colour first
   task automatic predict_tick();
      logic [7:0] b;
      if (pixel_bytes_left == '0) return;
      b = pixel_bytes_left[0] ? fill_rgb[7:0] : fill_rgb[15:8];
      pixel_bytes_left = pixel_bytes_left - 1'b1;
      queue_byte(b, 1'b1, 1'b1, pixel_bytes_left == '0);
   endtask

   always @(posedge clock) begin : watch
      link_byte_type got;
      link_byte_type want;
      if (reset) begin
         screen_w         = RESET_WIDTH;
         screen_h         = RESET_HEIGHT;
         pixel_bytes_left = '0;
         fill_rgb         = '0;
         errors           = 0;
         bytes_due.delete();
      end else begin
         // Track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               ADDR_SCREEN_WIDTH:  screen_w = csr_pwdata[9:0];
               ADDR_SCREEN_HEIGHT: screen_h = csr_pwdata[9:0];
               default: ;
            endcase
         end
         // Predict from each accepted item
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_TICK) predict_tick();
            else predict_start(req_tdata);
         end
         // Compare each accepted response byte
         if (rsp_tvalid && rsp_tready) begin
            got.bus_byte    = rsp_tdata;
            got.is_data     = rsp_tuser[0];
            got.last_of_run = rsp_tlast;
            got.fill_done   = rsp_tuser[1];
            if (bytes_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected byte %02h data %b last %b done %b, nothing due",
                        $time, got.bus_byte, got.is_data, got.last_of_run, got.fill_done);
            end else begin
               want = bytes_due.pop_front();
               if (got.bus_byte !== want.bus_byte || got.is_data !== want.is_data ||
                   got.last_of_run !== want.last_of_run ||
                   got.fill_done !== want.fill_done) begin
                  errors++;
                  $display("%0t: expected byte %02h data %b last %b done %b, got %02h %b %b %b",
                           $time, want.bus_byte, want.is_data, want.last_of_run,
                           want.fill_done, got.bus_byte, got.is_data, got.last_of_run,
                           got.fill_done);
               end
            end
         end
      end
      mismatch_count <= errors;
      bytes_pending  <= bytes_due.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the rectangle-fill command stream: a directed pass over the
// clipping corner cases, then phases at several screen sizes made mostly of
// complete fills (start, then one tick per pixel byte) with ignored starts,
// idle ticks and dropped rectangles mixed in. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb
   import lcdrf_pkg::*;
();

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_GOAL = 480;
   localparam int PHASES = 10;
   localparam logic [2:0] ADDR_SCREEN_WIDTH  = {REG_SCREEN_WIDTH, 2'b00};
   localparam logic [2:0] ADDR_SCREEN_HEIGHT = {REG_SCREEN_HEIGHT, 2'b00};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // rect_x, rect_y, rect_w, rect_h, fill_colour, zero pad
   logic        req_tuser;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // bus_byte
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;   // is_data, fill_done
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatch_count;
   int          bytes_pending;

   int stall_pct = 0;
   int rsp_hold = 0;
   int cycles = 0;
   int counted = 0;
   int scr_w = 320;
   int scr_h = 240;

   // Phase screen sizes; -1 picks a random size
   int phase_w[PHASES] = '{1023, 3, 1, 0, 320, 640, 4, 1023, -1, 320};
   int phase_h[PHASES] = '{1023, 2, 1, 240, 0, 480, 4, 1, -1, 240};

   lcd_rect_fill_command_stream i_dut (.*);
   lcd_fill_stream_checker i_checker (.*);

   always #HALF_PERIOD clock = ~clock;

   // End the run if it hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stall the response side in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_hold   <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_hold   <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one item, sometimes with a random gap ahead of it, and wait for acceptance
   task automatic drive_item(input logic cmd, input int x, input int y, input int w,
                             input int h, input logic [15:0] rgb);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, rgb, 11'(h), 11'(w), 11'(y), 11'(x)};
      do @(posedge clock); while (!req_tready);
      counted += 1;
   endtask

   task automatic send_tick();
      drive_item(CMD_TICK, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
   endtask

   task automatic send_wild_start();
      drive_item(CMD_START, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
   endtask

   // Start that clips to nothing on a non-empty screen
   task automatic send_empty_start();
      int x;
      int w;
      x = int'($urandom_range(0, 2047)) - 1024;
      w = -int'($urandom_range(0, 1024));
      case ($urandom_range(0, 2))
         0: ;
         1: begin
            x = $urandom_range(scr_w, 1023);
            w = int'($urandom_range(0, 2047)) - 1024;
         end
         default: begin
            x = -int'($urandom_range(1, 1024));
            w = $urandom_range(0, (-x > 1023) ? 1023 : -x);
         end
      endcase
      drive_item(CMD_START, x, $urandom, w, $urandom, 16'($urandom));
   endtask

   // Stop sending until every due byte has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (bytes_pending != 0);
   endtask

   task automatic csr_write(input logic [2:0] addr, input int value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Start a fill of known clipped size, then tick out every pixel byte
   task automatic run_fill(input int x, input int y, input int w, input int h,
                           input logic [15:0] rgb, input int kept_w, input int kept_h);
      drive_item(CMD_START, x, y, w, h, rgb);
      for (int i = 0; i < kept_w * kept_h * 2; i++) begin
         if ($urandom_range(0, 11) == 0) send_wild_start();
         send_tick();
      end
      if ($urandom_range(0, 5) == 0) send_tick();
   endtask

   // Span that clips to a small known length: inside, or hanging off either edge
   task automatic pick_span(input int screen, output int pos, output int len,
                            output int kept);
      int k;
      k = $urandom_range(1, (screen < 4) ? screen : 4);
      case ($urandom_range(0, 3))
         0, 1: begin
            pos = $urandom_range(0, screen - k);
            len = k;
         end
         2: begin
            pos = -int'($urandom_range(1, 1023 - k));
            len = k - pos;
         end
         default: begin
            pos = screen - k;
            len = k + int'($urandom_range(1, 1023 - k));
         end
      endcase
      kept = k;
   endtask

   task automatic play_step();
      int r;
      int x;
      int y;
      int w;
      int h;
      int cw;
      int ch;
      r = $urandom_range(0, 19);
      if (r == 0) begin
         send_empty_start();
      end else if (r == 1) begin
         send_tick();
      end else if (r < 5 && scr_w * scr_h <= 16) begin
         // Any rectangle clips to a few bytes here; tick past the end
         send_wild_start();
         repeat (scr_w * scr_h * 2 + $urandom_range(0, 2)) send_tick();
      end else begin
         pick_span(scr_w, x, w, cw);
         pick_span(scr_h, y, h, ch);
         run_fill(x, y, w, h, 16'($urandom), cw, ch);
         if ($urandom_range(0, 39) == 0) wait_drained();
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tuser   <= CMD_START;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at the reset screen size
      stall_pct = 10;
      drive_item(CMD_TICK, -1024, 1023, -1, 0, 16'hFFFF);
      drive_item(CMD_START, -1024, 0, 1023, 1, 16'h1234);
      drive_item(CMD_START, 0, 0, 0, 5, 16'h0001);
      drive_item(CMD_START, 10, -1024, 4, -1024, 16'h8000);
      drive_item(CMD_START, 1023, 0, 5, 5, 16'h7FFF);
      drive_item(CMD_START, 318, 5, -1024, 1023, 16'h5555);
      drive_item(CMD_START, -3, -2, 4, 3, 16'hFFFF);
      drive_item(CMD_START, 0, 0, 5, 5, 16'h0F0F);
      send_tick();
      send_tick();
      send_tick();
      run_fill(319, 239, 1023, 1023, 16'h0000, 1, 1);
      run_fill(2, 3, 2, 1, 16'hA55A, 2, 1);

      // Random phases, registers rewritten between them while idle
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         scr_w = (phase_w[p] < 0) ? int'($urandom_range(1, 1023)) : phase_w[p];
         scr_h = (phase_h[p] < 0) ? int'($urandom_range(1, 1023)) : phase_h[p];
         csr_write(ADDR_SCREEN_WIDTH, scr_w);
         csr_write(ADDR_SCREEN_HEIGHT, scr_h);
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 10;
            default: stall_pct = 35;
         endcase
         if (p == PHASES - 1) stall_pct = 0;
         if (scr_w == 0 || scr_h == 0) begin
            // Every start clips away and every tick is idle
            repeat (12) begin
               if ($urandom_range(0, 1) == 0) send_wild_start();
               else send_tick();
            end
         end else begin
            // One column at the far corner of the largest screen
            if (p == 0) run_fill(1022, 1000, 1, 1023, 16'($urandom), 1, 23);
            while (counted < ITEM_GOAL * (p + 1) / PHASES) play_step();
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
